// ----- rtl/core/uer_pkg.sv -----
// Package with the shared constants and types of the ultrasonic echo ranger.
package uer_pkg;

    localparam int MODE_BITS     = 2;
    localparam int CAPTURE_BITS  = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int PERIOD_BITS   = 16;
    localparam int TIMEOUT_BITS  = 16;
    localparam int SCALE_BITS    = 10;
    localparam int MS_BITS       = 32;
    localparam int WIDTH_BITS    = 24;
    localparam int DIST_BITS     = 25;
    localparam int PROD_BITS     = WIDTH_BITS + SCALE_BITS;
    localparam int RECIP_BITS    = 64;
    localparam int RECIP_SHIFT   = 37;
    localparam int S_TDATA_BITS  = 16;
    localparam int S_TUSER_BITS  = 2;
    localparam int M_TDATA_BITS  = 56;
    localparam int M_TUSER_BITS  = 3;

    localparam int DEF_COUNTER_BITS  = 16;
    localparam int DEF_OVERFLOW_BITS = 8;

    localparam logic [MODE_BITS-1:0] MODE_TICK     = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_RISE     = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_FALL     = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_OVERFLOW = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE   = 2'd2;

    localparam logic [PERIOD_BITS-1:0]  PERIOD_RESET  = 16'd500;
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd60;
    localparam logic [SCALE_BITS-1:0]   SCALE_RESET   = 10'd170;

    // Products at or above 100 * 2^25 give a distance beyond the output range.
    localparam logic [PROD_BITS-1:0] SAT_THRESHOLD = 34'd3355443200;
    // Reciprocal of 100 scaled by 2^37, exact for every 32-bit dividend.
    localparam logic [31:0]          RECIP_100     = 32'd1374389535;
    localparam logic [DIST_BITS-1:0] DIST_MAX      = {DIST_BITS{1'b1}};

    typedef struct packed {
        logic                  trigger_request;
        logic                  timeout_flag;
        logic                  report_valid;
        logic [WIDTH_BITS-1:0] echo_width;
    } uer_flags_t;

endpackage

// ----- rtl/core/ultrasonic_echo_ranger.sv -----
// Top level of the ultrasonic echo ranger with its event logic and distance pipeline.
//
// The ranger takes one event per request on the slave stream (kind in s_tuser, capture
// value in s_tdata) and accepts a new request in every cycle while the output side keeps
// up. The state is updated in the cycle a request is accepted; a millisecond tick that
// raises a trigger, a timeout or a report produces one result, registered in turn in
// the width times scale product, the reciprocal multiply that divides by 100 and the
// output register. Any stall on the master side holds the whole pipeline and drops
// s_tready. Configuration writes are taken in every cycle and should only be issued
// while no result is pending.
module ultrasonic_echo_ranger #(
    parameter int COUNTER_BITS  = uer_pkg::DEF_COUNTER_BITS,
    parameter int OVERFLOW_BITS = uer_pkg::DEF_OVERFLOW_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [uer_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [uer_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: capture_value[15:0].
    input  logic [uer_pkg::S_TDATA_BITS-1:0]     s_tdata,
    // Fields from bit 0: mode[1:0].
    input  logic [uer_pkg::S_TUSER_BITS-1:0]     s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0: echo_width[23:0], range_mm[48:24], zero fill[55:49].
    output logic [uer_pkg::M_TDATA_BITS-1:0]     m_tdata,
    // Fields from bit 0: trigger_request, timeout_flag, report_valid.
    output logic [uer_pkg::M_TUSER_BITS-1:0]     m_tuser
);
    import uer_pkg::*;

    localparam int CAP_BITS = (COUNTER_BITS < CAPTURE_BITS) ? COUNTER_BITS : CAPTURE_BITS;
    localparam int SUM_BITS = (OVERFLOW_BITS + COUNTER_BITS > WIDTH_BITS)
                              ? OVERFLOW_BITS + COUNTER_BITS : WIDTH_BITS;

    logic [PERIOD_BITS-1:0]   period_reg;
    logic [TIMEOUT_BITS-1:0]  timeout_reg;
    logic [SCALE_BITS-1:0]    scale_reg;

    logic [MS_BITS-1:0]       ms_count_reg, ms_count_next;
    logic [MS_BITS-1:0]       last_trigger_reg, last_trigger_next;
    logic [MS_BITS-1:0]       echo_start_reg, echo_start_next;
    logic                     echo_open_reg, echo_open_next;
    logic [OVERFLOW_BITS-1:0] overflow_reg, overflow_next;
    logic [CAP_BITS-1:0]      first_capture_reg, first_capture_next;
    logic [WIDTH_BITS-1:0]    width_store_reg, width_store_next;
    logic                     fresh_reg, fresh_next;

    logic                     s1_valid_reg, s2_valid_reg, out_valid_reg;
    uer_flags_t               s1_flags_reg, s2_flags_reg, out_flags_reg;
    logic [PROD_BITS-1:0]     s1_prod_reg;
    logic [RECIP_BITS-1:0]    s2_recip_reg;
    logic                     s2_sat_reg;
    logic [DIST_BITS-1:0]     out_dist_reg;

    logic                     advance;
    logic                     accept;
    logic [MODE_BITS-1:0]     mode;
    logic [CAP_BITS-1:0]      cap;
    logic [SUM_BITS-1:0]      width_sum;
    logic                     trig, tmo, rep, open_after_trig, fresh_after_trig;
    logic [WIDTH_BITS-1:0]    width_after;
    uer_flags_t               flags;
    logic                     has_result;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = advance;
    assign accept    = s_tvalid && advance;
    assign mode      = s_tuser[MODE_BITS-1:0];
    assign cap       = s_tdata[CAP_BITS-1:0];

    assign width_sum = (SUM_BITS'(overflow_reg) << COUNTER_BITS) + SUM_BITS'(cap)
                       - SUM_BITS'(first_capture_reg);

    always_comb
    begin
        ms_count_next      = ms_count_reg;
        last_trigger_next  = last_trigger_reg;
        echo_start_next    = echo_start_reg;
        echo_open_next     = echo_open_reg;
        overflow_next      = overflow_reg;
        first_capture_next = first_capture_reg;
        width_store_next   = width_store_reg;
        fresh_next         = fresh_reg;
        trig               = 1'b0;
        tmo                = 1'b0;
        rep                = 1'b0;
        open_after_trig    = echo_open_reg;
        fresh_after_trig   = fresh_reg;
        width_after        = width_store_reg;
        unique case (mode)
            MODE_RISE:
            begin
                first_capture_next = cap;
                echo_open_next     = 1'b1;
                overflow_next      = '0;
                echo_start_next    = ms_count_reg;
            end
            MODE_FALL:
            begin
                if (echo_open_reg)
                begin
                    width_store_next = width_sum[WIDTH_BITS-1:0];
                    echo_open_next   = 1'b0;
                    fresh_next       = 1'b1;
                end
            end
            MODE_OVERFLOW:
            begin
                if (echo_open_reg && (overflow_reg != {OVERFLOW_BITS{1'b1}}))
                begin
                    overflow_next = overflow_reg + 1'b1;
                end
            end
            default:
            begin
                ms_count_next    = ms_count_reg + 1'b1;
                trig             = (ms_count_next - last_trigger_reg)
                                   >= MS_BITS'(period_reg);
                open_after_trig  = echo_open_reg && !trig;
                fresh_after_trig = fresh_reg && !trig;
                tmo              = open_after_trig && ((ms_count_next - echo_start_reg)
                                   > MS_BITS'(timeout_reg));
                width_after      = (trig || tmo) ? '0 : width_store_reg;
                rep              = fresh_after_trig && (width_after != '0);
                if (trig)
                begin
                    last_trigger_next = ms_count_next;
                end
                echo_open_next   = open_after_trig && !tmo;
                width_store_next = width_after;
                fresh_next       = fresh_after_trig && !rep;
            end
        endcase
    end

    always_comb
    begin
        flags.trigger_request = trig;
        flags.timeout_flag    = tmo;
        flags.report_valid    = rep;
        flags.echo_width      = rep ? width_after : '0;
    end

    assign has_result = trig || tmo || rep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= PERIOD_RESET;
            timeout_reg <= TIMEOUT_RESET;
            scale_reg   <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PERIOD:  period_reg  <= cfg_data[PERIOD_BITS-1:0];
                REG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_BITS-1:0];
                REG_SCALE:   scale_reg   <= cfg_data[SCALE_BITS-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_count_reg      <= '0;
            last_trigger_reg  <= '0;
            echo_start_reg    <= '0;
            echo_open_reg     <= 1'b0;
            overflow_reg      <= '0;
            first_capture_reg <= '0;
            width_store_reg   <= '0;
            fresh_reg         <= 1'b0;
        end
        else if (accept)
        begin
            ms_count_reg      <= ms_count_next;
            last_trigger_reg  <= last_trigger_next;
            echo_start_reg    <= echo_start_next;
            echo_open_reg     <= echo_open_next;
            overflow_reg      <= overflow_next;
            first_capture_reg <= first_capture_next;
            width_store_reg   <= width_store_next;
            fresh_reg         <= fresh_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept && (mode == MODE_TICK) && has_result;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_flags_reg  <= flags;
            s1_prod_reg   <= PROD_BITS'(flags.echo_width) * PROD_BITS'(scale_reg);
            s2_flags_reg  <= s1_flags_reg;
            s2_sat_reg    <= s1_prod_reg >= SAT_THRESHOLD;
            s2_recip_reg  <= RECIP_BITS'(s1_prod_reg[31:0]) * RECIP_BITS'(RECIP_100);
            out_flags_reg <= s2_flags_reg;
            out_dist_reg  <= s2_sat_reg ? DIST_MAX
                             : s2_recip_reg[RECIP_SHIFT+DIST_BITS-1:RECIP_SHIFT];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_BITS-WIDTH_BITS-DIST_BITS){1'b0}}, out_dist_reg,
                       out_flags_reg.echo_width};
    assign m_tuser  = {out_flags_reg.report_valid, out_flags_reg.timeout_flag,
                       out_flags_reg.trigger_request};

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the ultrasonic echo ranger stream block.
module testbench;
    import uer_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
    localparam int OVF_LIMIT = (1 << DEF_OVERFLOW_BITS) - 1;
    localparam int MAX_SHOWN = 10;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [MODE_BITS-1:0]    kind;
        logic [CAPTURE_BITS-1:0] capture;
    } sensor_event_t;

    typedef struct {
        logic                  trigger;
        logic                  timed_out;
        logic                  fresh;
        logic [WIDTH_BITS-1:0] width;
        logic [DIST_BITS-1:0]  distance;
    } range_report_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_BITS-1:0]   s_tdata = '0;
    logic [S_TUSER_BITS-1:0]   s_tuser = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]   m_tdata;
    logic [M_TUSER_BITS-1:0]   m_tuser;

    // Predicted ranger state and settings.
    logic [PERIOD_BITS-1:0]    period_set = PERIOD_RESET;
    logic [TIMEOUT_BITS-1:0]   timeout_set = TIMEOUT_RESET;
    logic [SCALE_BITS-1:0]     scale_set = SCALE_RESET;
    logic [MS_BITS-1:0]        ms_now = '0;
    logic [MS_BITS-1:0]        last_trigger = '0;
    logic [MS_BITS-1:0]        echo_begin = '0;
    logic                      echo_live = 1'b0;
    logic [7:0]                wrap_count = '0;
    logic [CAPTURE_BITS-1:0]   rise_mark = '0;
    logic [WIDTH_BITS-1:0]     held_width = '0;
    logic                      width_fresh = 1'b0;

    sensor_event_t             pending_events[$];
    range_report_t             expected_ranges[$];

    int  events_outstanding = 0;
    int  events_accepted = 0;
    int  results_checked = 0;
    int  reports_seen = 0;
    int  triggers_seen = 0;
    int  timeouts_seen = 0;
    int  settings_written = 0;
    int  mismatches = 0;
    int  holds_asked = 0;
    int  holds_done = 0;
    int  send_gap = 0;
    int  hold_left = 0;
    bit  sender_gaps = 1'b1;
    bit  receiver_gaps = 1'b1;

    ultrasonic_echo_ranger dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void apply_setting(input logic [CFG_IDX_BITS-1:0] idx,
                                          input logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            REG_PERIOD:  period_set = value;
            REG_TIMEOUT: timeout_set = value;
            REG_SCALE:   scale_set = value[SCALE_BITS-1:0];
            default:     ;
        endcase
    endfunction

    function automatic void range_step(input sensor_event_t ev);
        logic [MS_BITS-1:0]   since;
        logic [PROD_BITS-1:0] product;
        logic [PROD_BITS-1:0] quotient;
        range_report_t        r;
        r = '{trigger: 1'b0, timed_out: 1'b0, fresh: 1'b0, width: '0, distance: '0};
        case (ev.kind)
            MODE_RISE:
            begin
                rise_mark = ev.capture;
                echo_live = 1'b1;
                wrap_count = '0;
                echo_begin = ms_now;
            end
            MODE_FALL:
            begin
                if (echo_live)
                begin
                    held_width = {wrap_count, 16'h0000} + WIDTH_BITS'(ev.capture)
                                 - WIDTH_BITS'(rise_mark);
                    echo_live = 1'b0;
                    width_fresh = 1'b1;
                end
            end
            MODE_OVERFLOW:
            begin
                if (echo_live && wrap_count != OVF_LIMIT)
                    wrap_count = wrap_count + 1'b1;
            end
            default:
            begin
                ms_now = ms_now + 1'b1;
                since = ms_now - last_trigger;
                if (since >= MS_BITS'(period_set))
                begin
                    r.trigger = 1'b1;
                    last_trigger = ms_now;
                    echo_live = 1'b0;
                    held_width = '0;
                    width_fresh = 1'b0;
                end
                since = ms_now - echo_begin;
                if (echo_live && since > MS_BITS'(timeout_set))
                begin
                    echo_live = 1'b0;
                    held_width = '0;
                    r.timed_out = 1'b1;
                end
                if (width_fresh && held_width != '0)
                begin
                    r.fresh = 1'b1;
                    r.width = held_width;
                    product = held_width * scale_set;
                    quotient = product / 100;
                    r.distance = (quotient > PROD_BITS'(DIST_MAX)) ? DIST_MAX
                                                                   : quotient[DIST_BITS-1:0];
                    width_fresh = 1'b0;
                end
                if (r.trigger || r.timed_out || r.fresh)
                    expected_ranges.push_back(r);
            end
        endcase
    endfunction

    function automatic void queue_event(input logic [MODE_BITS-1:0] kind,
                                        input logic [CAPTURE_BITS-1:0] capture);
        sensor_event_t ev;
        ev.kind = kind;
        ev.capture = capture;
        pending_events.push_back(ev);
        events_outstanding++;
    endfunction

    function automatic logic [CAPTURE_BITS-1:0] any_capture();
        return CAPTURE_BITS'($urandom_range(0, 65535));
    endfunction

    // Mostly complete echo measurements, with timeouts, bare ticks and noise mixed in.
    function automatic int queue_burst();
        int pick;
        int count;
        int n;
        pick = $urandom_range(0, 99);
        count = 0;
        if (pick < 55)
        begin
            queue_event(MODE_RISE, any_capture());
            n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            repeat (n) queue_event(MODE_OVERFLOW, any_capture());
            queue_event(MODE_FALL, any_capture());
            count = n + 2;
            n = $urandom_range(1, 3);
            repeat (n) queue_event(MODE_TICK, any_capture());
            count += n;
        end
        else if (pick < 75)
        begin
            n = $urandom_range(1, 8);
            repeat (n) queue_event(MODE_TICK, any_capture());
            count = n;
        end
        else if (pick < 87)
        begin
            queue_event(MODE_RISE, any_capture());
            n = $urandom_range(1, 20);
            repeat (n) queue_event(MODE_TICK, any_capture());
            count = n + 1;
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n) queue_event(MODE_BITS'($urandom_range(0, 3)), any_capture());
            count = n;
        end
        return count;
    endfunction

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
            note_failure($sformatf("%s expected %0h got %0h", name, want, got));
    endfunction

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        sensor_event_t ev;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                ev.kind = s_tuser;
                ev.capture = s_tdata;
                range_step(ev);
                events_accepted++;
                events_outstanding--;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_events.size() != 0)
                begin
                    ev = pending_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= ev.capture;
                    s_tuser <= ev.kind;
                    send_gap = sender_gaps ? pick_gap() : 0;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver with random and long stalls.
    always @(posedge clk or negedge rst_n)
    begin
        int pick;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (holds_done < holds_asked)
            begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!receiver_gaps)
                m_tready <= 1'b1;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    m_tready <= 1'b1;
                else
                begin
                    hold_left = (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        range_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_ranges.size() == 0)
                note_failure($sformatf("unexpected result tuser %0h tdata %0h", m_tuser, m_tdata));
            else
            begin
                want = expected_ranges.pop_front();
                results_checked++;
                triggers_seen += want.trigger;
                timeouts_seen += want.timed_out;
                reports_seen += want.fresh;
                check_field("trigger_request", want.trigger, m_tuser[0]);
                check_field("timeout_flag", want.timed_out, m_tuser[1]);
                check_field("report_valid", want.fresh, m_tuser[2]);
                check_field("echo_width", want.width, m_tdata[WIDTH_BITS-1:0]);
                check_field("range_mm", want.distance, m_tdata[WIDTH_BITS +: DIST_BITS]);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_setting(idx, value);
        settings_written++;
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (events_outstanding != 0 || expected_ranges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int added;
        int phase;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: closed-echo events, restart while open, fall below rise,
        // zero width and a later report.
        queue_event(MODE_TICK, 16'hFFFF);
        queue_event(MODE_FALL, 16'hFFFF);
        queue_event(MODE_OVERFLOW, 16'h0000);
        queue_event(MODE_RISE, 16'h1234);
        queue_event(MODE_OVERFLOW, 16'hFFFF);
        queue_event(MODE_RISE, 16'hFFFF);
        queue_event(MODE_OVERFLOW, 16'h5555);
        queue_event(MODE_OVERFLOW, 16'hAAAA);
        queue_event(MODE_FALL, 16'h0000);
        queue_event(MODE_TICK, 16'h0000);
        queue_event(MODE_RISE, 16'h8000);
        queue_event(MODE_FALL, 16'h8000);
        queue_event(MODE_TICK, 16'h0000);
        queue_event(MODE_RISE, 16'h0001);
        queue_event(MODE_FALL, 16'h0101);
        queue_event(MODE_TICK, 16'h0000);
        wait_idle();

        // Short period and timeout: an echo that times out, then a trigger.
        write_reg(REG_PERIOD, 16'd8);
        write_reg(REG_TIMEOUT, 16'd2);
        write_reg(REG_SCALE, 16'hFFFF);
        queue_event(MODE_RISE, 16'h0000);
        repeat (4) queue_event(MODE_TICK, 16'h0000);
        wait_idle();

        // Long echo: overflow count saturates and the distance clips.
        write_reg(REG_PERIOD, 16'hFFFF);
        write_reg(REG_TIMEOUT, 16'hFFFF);
        queue_event(MODE_RISE, 16'hFFFF);
        repeat (OVF_LIMIT + 5) queue_event(MODE_OVERFLOW, any_capture());
        queue_event(MODE_FALL, 16'hFFFE);
        queue_event(MODE_TICK, 16'h0000);
        wait_idle();

        // Output held off while a trigger result per tick keeps coming.
        write_reg(REG_PERIOD, 16'd1);
        sender_gaps = 1'b0;
        holds_asked++;
        repeat (40) queue_event(MODE_TICK, any_capture());
        wait_idle();

        for (phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_PERIOD, 16'd0);
                    write_reg(REG_TIMEOUT, 16'd5);
                    write_reg(REG_SCALE, any_capture());
                end
                1:
                begin
                    write_reg(REG_PERIOD, 16'd30);
                    write_reg(REG_TIMEOUT, 16'd0);
                    write_reg(REG_SCALE, {6'(any_capture()), 10'h3FF});
                    write_reg(REG_SPARE, any_capture());
                end
                2:
                begin
                    write_reg(REG_PERIOD, 16'hFFFF);
                    write_reg(REG_TIMEOUT, 16'hFFFF);
                    write_reg(REG_SCALE, {6'(any_capture()), 10'h000});
                end
                3:
                begin
                    write_reg(REG_PERIOD, 16'd20);
                    write_reg(REG_TIMEOUT, 16'd1);
                    write_reg(REG_SCALE, 16'd1);
                end
                default:
                begin
                    write_reg(REG_PERIOD, 16'($urandom_range(5, 60)));
                    write_reg(REG_TIMEOUT, 16'($urandom_range(1, 15)));
                    write_reg(REG_SCALE, any_capture());
                end
            endcase
            sender_gaps = ($urandom_range(0, 3) != 0);
            receiver_gaps = ($urandom_range(0, 3) != 0);
            added = 0;
            while (added < 25)
                added += queue_burst();
            wait_idle();
        end

        repeat (20) @(posedge clk);
        $display("Sent %0d events over %0d register writes; checked %0d results.",
                 events_accepted, settings_written, results_checked);
        $display("Results held %0d triggers, %0d timeouts and %0d range reports.",
                 triggers_seen, timeouts_seen, reports_seen);
        if (mismatches == 0 && expected_ranges.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
